@@ rtl/core/tbce_pkg.sv @@
`timescale 1ns / 1ps
// Package for the text to Braille cell encoder.
// Holds cell types, register indexes, reset values and symbol tables.
package tbce_pkg;

  localparam int unsigned PatW = 6;
  localparam int unsigned IdxW = 4;

  localparam logic [1:0] RegNumSign = 2'd0;
  localparam logic [1:0] RegCapSign = 2'd1;
  localparam logic [1:0] RegSpace   = 2'd2;
  localparam logic [1:0] RegMirror  = 2'd3;

  localparam logic [PatW-1:0] NumSignRst = 6'h3C;
  localparam logic [PatW-1:0] CapSignRst = 6'h20;
  localparam logic [PatW-1:0] SpaceRst   = 6'h00;

  localparam logic [7:0] ChrDigit0 = 8'h30;
  localparam logic [7:0] ChrDigit9 = 8'h39;
  localparam logic [7:0] ChrUpperA = 8'h41;
  localparam logic [7:0] ChrUpperZ = 8'h5A;
  localparam logic [7:0] ChrLowerA = 8'h61;
  localparam logic [7:0] ChrLowerZ = 8'h7A;
  localparam logic [7:0] ChrSpace  = 8'h20;
  localparam logic [7:0] ChrExcl   = 8'h21;
  localparam logic [7:0] ChrApos   = 8'h27;
  localparam logic [7:0] ChrHyphen = 8'h2D;
  localparam logic [7:0] ChrPeriod = 8'h2E;
  localparam logic [7:0] ChrComma  = 8'h2C;
  localparam logic [7:0] ChrQuest  = 8'h3F;
  localparam logic [7:0] ChrSemi   = 8'h3B;
  localparam logic [7:0] ChrColon  = 8'h3A;

  typedef struct packed {
    logic [PatW-1:0] num_sign;
    logic [PatW-1:0] cap_sign;
    logic [PatW-1:0] space;
    logic            mirror;
  } cfg_t;

  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic [PatW-1:0] dots;
    logic            last;
  } cell_t;

  typedef struct packed {
    logic [1:0] cnt;
    cell_t      c0;
    cell_t      c1;
  } pair_t;

  function automatic logic [PatW-1:0] letter_cell(input logic [4:0] i);
    logic [PatW-1:0] p;
    case (i)
      5'd0:  p = 6'h01;
      5'd1:  p = 6'h03;
      5'd2:  p = 6'h09;
      5'd3:  p = 6'h19;
      5'd4:  p = 6'h11;
      5'd5:  p = 6'h0B;
      5'd6:  p = 6'h1B;
      5'd7:  p = 6'h13;
      5'd8:  p = 6'h0A;
      5'd9:  p = 6'h1A;
      5'd10: p = 6'h05;
      5'd11: p = 6'h07;
      5'd12: p = 6'h0D;
      5'd13: p = 6'h1D;
      5'd14: p = 6'h15;
      5'd15: p = 6'h0F;
      5'd16: p = 6'h1F;
      5'd17: p = 6'h17;
      5'd18: p = 6'h0E;
      5'd19: p = 6'h1E;
      5'd20: p = 6'h25;
      5'd21: p = 6'h27;
      5'd22: p = 6'h3A;
      5'd23: p = 6'h2D;
      5'd24: p = 6'h3D;
      5'd25: p = 6'h35;
      default: p = 6'h00;
    endcase
    return p;
  endfunction

  function automatic logic [PatW-1:0] digit_cell(input logic [3:0] i);
    logic [PatW-1:0] p;
    case (i)
      4'd0: p = 6'h1A;
      4'd1: p = 6'h01;
      4'd2: p = 6'h03;
      4'd3: p = 6'h09;
      4'd4: p = 6'h19;
      4'd5: p = 6'h11;
      4'd6: p = 6'h0B;
      4'd7: p = 6'h1B;
      4'd8: p = 6'h13;
      4'd9: p = 6'h0A;
      default: p = 6'h00;
    endcase
    return p;
  endfunction

  function automatic logic [PatW-1:0] punct_cell(input logic [7:0] c);
    logic [PatW-1:0] p;
    case (c)
      ChrExcl:   p = 6'h16;
      ChrApos:   p = 6'h04;
      ChrHyphen: p = 6'h24;
      ChrPeriod: p = 6'h32;
      ChrComma:  p = 6'h02;
      ChrQuest:  p = 6'h26;
      ChrSemi:   p = 6'h06;
      ChrColon:  p = 6'h12;
      default:   p = 6'h00;
    endcase
    return p;
  endfunction

endpackage

@@ rtl/core/tbce_if.sv @@
`timescale 1ns / 1ps
// Handshake channels of the Braille encoder: character requests and cells.
// No dependencies.
interface tbce_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       start_of_text;
  logic [7:0] start_cell;
  modport source (output valid, char_code, start_of_text, start_cell, input ready);
  modport sink (input valid, char_code, start_of_text, start_cell, output ready);
endinterface

interface tbce_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] cell_index;
  logic [5:0] dot_pattern;
  logic       last_of_char;
  modport source (output valid, cell_index, dot_pattern, last_of_char, input ready);
  modport sink (input valid, cell_index, dot_pattern, last_of_char, output ready);
endinterface

@@ rtl/core/tbce_cfg.sv @@
`timescale 1ns / 1ps
// APB configuration registers of the Braille encoder.
// Depends on tbce_pkg.
module tbce_cfg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output tbce_pkg::cfg_t       cfg_o
);

  tbce_pkg::cfg_t cfg_q, cfg_d;
  logic           wr;

  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (paddr[3:2])
        tbce_pkg::RegNumSign: cfg_d.num_sign = pwdata[5:0];
        tbce_pkg::RegCapSign: cfg_d.cap_sign = pwdata[5:0];
        tbce_pkg::RegSpace:   cfg_d.space    = pwdata[5:0];
        tbce_pkg::RegMirror:  cfg_d.mirror   = pwdata[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      tbce_pkg::RegNumSign: prdata = {26'd0, cfg_q.num_sign};
      tbce_pkg::RegCapSign: prdata = {26'd0, cfg_q.cap_sign};
      tbce_pkg::RegSpace:   prdata = {26'd0, cfg_q.space};
      tbce_pkg::RegMirror:  prdata = {31'd0, cfg_q.mirror};
      default:              prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_sign <= tbce_pkg::NumSignRst;
      cfg_q.cap_sign <= tbce_pkg::CapSignRst;
      cfg_q.space    <= tbce_pkg::SpaceRst;
      cfg_q.mirror   <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ rtl/core/tbce_encoder.sv @@
`timescale 1ns / 1ps
// Character to cell-pair translation with cell position and number mode state.
// Depends on tbce_pkg.
module tbce_encoder #(
  parameter int unsigned CELL_COUNT = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      char_code_i,
  input  logic            start_of_text_i,
  input  logic [7:0]      start_cell_i,
  input  tbce_pkg::cfg_t  cfg_i,
  output tbce_pkg::pair_t pair_o
);

  localparam int unsigned NW = $clog2(CELL_COUNT + 1);
  localparam logic [NW-1:0] Full = NW'(CELL_COUNT);

  logic [NW-1:0] next_cell_q, next_cell_d, nc, nc1;
  logic          number_mode_q, number_mode_d, nm;
  logic          is_digit, is_upper, is_lower, is_space;
  logic          has_sign, sym_emit, row_open;
  logic [5:0]    sign_raw, sym_raw, sign_p, sym_p;
  logic [7:0]    off_upper, off_lower, off_digit;

  assign off_upper = char_code_i - tbce_pkg::ChrUpperA;
  assign off_lower = char_code_i - tbce_pkg::ChrLowerA;
  assign off_digit = char_code_i - tbce_pkg::ChrDigit0;

  assign is_digit = char_code_i >= tbce_pkg::ChrDigit0 && char_code_i <= tbce_pkg::ChrDigit9;
  assign is_upper = char_code_i >= tbce_pkg::ChrUpperA && char_code_i <= tbce_pkg::ChrUpperZ;
  assign is_lower = char_code_i >= tbce_pkg::ChrLowerA && char_code_i <= tbce_pkg::ChrLowerZ;
  assign is_space = char_code_i == tbce_pkg::ChrSpace;

  always_comb begin
    if (start_of_text_i) begin
      nc = ({1'b0, start_cell_i} < 9'(CELL_COUNT)) ? NW'(start_cell_i) : Full;
      nm = 1'b0;
    end else begin
      nc = next_cell_q;
      nm = number_mode_q;
    end
    row_open = nc < Full;

    if (is_digit) begin
      sym_raw  = tbce_pkg::digit_cell(off_digit[3:0]);
      has_sign = !nm;
      sign_raw = cfg_i.num_sign;
    end else if (is_upper) begin
      sym_raw  = tbce_pkg::letter_cell(off_upper[4:0]);
      has_sign = 1'b1;
      sign_raw = cfg_i.cap_sign;
    end else if (is_lower) begin
      sym_raw  = tbce_pkg::letter_cell(off_lower[4:0]);
      has_sign = 1'b0;
      sign_raw = cfg_i.cap_sign;
    end else if (is_space) begin
      sym_raw  = cfg_i.space;
      has_sign = 1'b0;
      sign_raw = cfg_i.cap_sign;
    end else begin
      sym_raw  = tbce_pkg::punct_cell(char_code_i);
      has_sign = 1'b0;
      sign_raw = cfg_i.cap_sign;
    end

    sign_p = cfg_i.mirror ? {sign_raw[2:0], sign_raw[5:3]} : sign_raw;
    sym_p  = cfg_i.mirror ? {sym_raw[2:0], sym_raw[5:3]} : sym_raw;

    nc1      = nc + NW'(has_sign);
    sym_emit = nc1 < Full;

    pair_o.c0.idx  = 4'(nc);
    pair_o.c0.dots = has_sign ? sign_p : sym_p;
    pair_o.c0.last = !(has_sign && sym_emit);
    pair_o.c1.idx  = 4'(nc1);
    pair_o.c1.dots = sym_p;
    pair_o.c1.last = 1'b1;

    if (row_open) begin
      pair_o.cnt    = 2'(has_sign) + 2'(sym_emit);
      next_cell_d   = nc1 + NW'(sym_emit);
      number_mode_d = is_digit;
    end else begin
      pair_o.cnt    = 2'd0;
      next_cell_d   = nc;
      number_mode_d = nm;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_cell_q   <= Full;
      number_mode_q <= 1'b0;
    end else if (accept_i) begin
      next_cell_q   <= next_cell_d;
      number_mode_q <= number_mode_d;
    end
  end

`ifndef SYNTH
  a_cell_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_cell_q <= Full)
    else $error("next cell beyond row");
`endif

endmodule

@@ rtl/core/tbce_serializer.sv @@
`timescale 1ns / 1ps
// Cell-pair buffer and output register; sends one cell per cycle while the receiver is ready.
// Depends on tbce_pkg.
module tbce_serializer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tbce_pkg::pair_t pair_i,
  output logic            free_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output tbce_pkg::cell_t out_cell_o
);

  tbce_pkg::pair_t pair_q, pair_d;
  tbce_pkg::cell_t out_q;
  logic            out_valid_q, out_valid_d;
  logic            take, load_out;

  assign take     = !out_valid_q || out_ready_i;
  assign load_out = take && (pair_q.cnt != 2'd0);
  assign free_o   = (pair_q.cnt == 2'd0) || ((pair_q.cnt == 2'd1) && take);

  assign out_valid_o = out_valid_q;
  assign out_cell_o  = out_q;

  always_comb begin
    pair_d = pair_q;
    if (push_i && pair_i.cnt != 2'd0) begin
      pair_d = pair_i;
    end else if (load_out) begin
      pair_d.cnt = pair_q.cnt - 2'd1;
      pair_d.c0  = pair_q.c1;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && !out_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      pair_q      <= pair_d;
      out_valid_q <= out_valid_d;
      if (load_out) begin
        out_q <= pair_q.c0;
      end
    end
  end

`ifndef SYNTH
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair_q.cnt != 2'd3)
    else $error("pair buffer overfilled");
  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair_q.cnt == 2'd2 |-> !pair_q.c0.last)
    else $error("sign cell marked last");
  a_symbol_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_ready_i && !out_q.last |=> out_valid_q)
    else $error("symbol cell missing after sign");
`endif

endmodule

@@ rtl/core/text_to_braille_cell_encoder_top.sv @@
`timescale 1ns / 1ps
// A character's first cell goes via the pair buffer into the output register.
// Throughput: one character per cycle when it yields one cell and the cell sink is ready;
// a sign cell delays later requests; the single cell output register sets this.
// Reset: asynchronous, active low; clears registers to defaults, row full, number mode off.
// Depends on tbce_pkg, tbce_if, tbce_cfg, tbce_encoder, tbce_serializer.
module text_to_braille_cell_encoder_top #(
  parameter int unsigned CELL_COUNT = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tbce_in_if.sink      req_i,
  tbce_out_if.source   cell_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  tbce_pkg::cfg_t  cfg;
  tbce_pkg::pair_t pair;
  tbce_pkg::cell_t out_cell;
  logic            free, accept;

  assign req_i.ready = free;
  assign accept      = req_i.valid && free;

  tbce_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tbce_encoder #(
    .CELL_COUNT (CELL_COUNT)
  ) u_encoder (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .char_code_i     (req_i.char_code),
    .start_of_text_i (req_i.start_of_text),
    .start_cell_i    (req_i.start_cell),
    .cfg_i           (cfg),
    .pair_o          (pair)
  );

  tbce_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .pair_i      (pair),
    .free_o      (free),
    .out_valid_o (cell_o.valid),
    .out_ready_i (cell_o.ready),
    .out_cell_o  (out_cell)
  );

  assign cell_o.cell_index   = out_cell.idx;
  assign cell_o.dot_pattern  = out_cell.dots;
  assign cell_o.last_of_char = out_cell.last;

endmodule

@@ tb/sv/text_to_braille_cell_encoder_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for text_to_braille_cell_encoder_top: random texts with capitals,
// digit runs and punctuation under random request/cell idling, checked against a predictor.
// Depends on tbce_pkg, tbce_if and the encoder top level.
module text_to_braille_cell_encoder_top_tb;

  localparam int CellCount = 16;
  localparam int PatW = tbce_pkg::PatW;
  localparam int IdxW = tbce_pkg::IdxW;

  localparam logic [0:25][PatW-1:0] LetterDots = {
    6'h01, 6'h03, 6'h09, 6'h19, 6'h11, 6'h0B, 6'h1B, 6'h13, 6'h0A, 6'h1A,
    6'h05, 6'h07, 6'h0D, 6'h1D, 6'h15, 6'h0F, 6'h1F, 6'h17, 6'h0E, 6'h1E,
    6'h25, 6'h27, 6'h3A, 6'h2D, 6'h3D, 6'h35
  };
  localparam logic [0:9][PatW-1:0] DigitDots = {
    6'h1A, 6'h01, 6'h03, 6'h09, 6'h19, 6'h11, 6'h0B, 6'h1B, 6'h13, 6'h0A
  };

  typedef struct packed {
    logic [7:0] code;
    logic       sot;
    logic [7:0] start;
  } char_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic        req_valid = 1'b0;
  logic [7:0]  req_code = '0;
  logic        req_sot = 1'b0;
  logic [7:0]  req_start = '0;
  logic        cell_ready = 1'b0;

  tbce_in_if  req_if ();
  tbce_out_if cell_if ();

  assign req_if.valid         = req_valid;
  assign req_if.char_code     = req_code;
  assign req_if.start_of_text = req_sot;
  assign req_if.start_cell    = req_start;
  assign cell_if.ready        = cell_ready;

  text_to_braille_cell_encoder_top #(.CELL_COUNT(CellCount)) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .cell_o  (cell_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  char_req_t       chars_pending [$];
  tbce_pkg::cell_t cells_due [$];
  char_req_t       next_char;
  tbce_pkg::cfg_t  shadow_cfg = '{num_sign: tbce_pkg::NumSignRst,
                                  cap_sign: tbce_pkg::CapSignRst,
                                  space: tbce_pkg::SpaceRst, mirror: 1'b0};
  int              row_pos = CellCount;
  logic            in_number = 1'b0;
  int              mismatch_cnt = 0;
  logic            idle_on = 1'b1;
  int              gap_left = 0;
  int              stall_left = 0;
  int              cells_taken = 0;
  logic            long_hold_done = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic tbce_pkg::cell_t place_cell(input logic [PatW-1:0] pat);
    tbce_pkg::cell_t c;
    c.idx  = row_pos[IdxW-1:0];
    c.dots = shadow_cfg.mirror ? {pat[2:0], pat[5:3]} : pat;
    c.last = 1'b0;
    row_pos++;
    return c;
  endfunction

  function automatic void encode_char(input char_req_t r);
    logic [PatW-1:0] sym;
    logic [PatW-1:0] sign;
    logic            has_sign;
    logic [7:0]      ofs;
    tbce_pkg::cell_t cells [2];
    int              n;
    has_sign = 1'b0;
    sign = '0;
    n = 0;
    if (r.sot) begin
      row_pos = (r.start < CellCount) ? int'(r.start) : CellCount;
      in_number = 1'b0;
    end
    if (row_pos >= CellCount) return;
    if (r.code >= tbce_pkg::ChrDigit0 && r.code <= tbce_pkg::ChrDigit9) begin
      ofs = r.code - tbce_pkg::ChrDigit0;
      sym = DigitDots[ofs[3:0]];
      if (!in_number) begin
        has_sign = 1'b1;
        sign = shadow_cfg.num_sign;
        in_number = 1'b1;
      end
    end else begin
      in_number = 1'b0;
      if (r.code >= tbce_pkg::ChrUpperA && r.code <= tbce_pkg::ChrUpperZ) begin
        ofs = r.code - tbce_pkg::ChrUpperA;
        sym = LetterDots[ofs[4:0]];
        has_sign = 1'b1;
        sign = shadow_cfg.cap_sign;
      end else if (r.code >= tbce_pkg::ChrLowerA && r.code <= tbce_pkg::ChrLowerZ) begin
        ofs = r.code - tbce_pkg::ChrLowerA;
        sym = LetterDots[ofs[4:0]];
      end else begin
        case (r.code)
          tbce_pkg::ChrSpace:  sym = shadow_cfg.space;
          tbce_pkg::ChrExcl:   sym = 6'h16;
          tbce_pkg::ChrApos:   sym = 6'h04;
          tbce_pkg::ChrHyphen: sym = 6'h24;
          tbce_pkg::ChrPeriod: sym = 6'h32;
          tbce_pkg::ChrComma:  sym = 6'h02;
          tbce_pkg::ChrQuest:  sym = 6'h26;
          tbce_pkg::ChrSemi:   sym = 6'h06;
          tbce_pkg::ChrColon:  sym = 6'h12;
          default:             sym = 6'h00;
        endcase
      end
    end
    if (has_sign) begin
      cells[n] = place_cell(sign);
      n++;
    end
    if (row_pos < CellCount) begin
      cells[n] = place_cell(sym);
      n++;
    end
    cells[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) cells_due.push_back(cells[i]);
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid <= 1'b0;
    end else if (req_valid && !req_if.ready) begin
      // hold the offered request
    end else if (gap_left > 0) begin
      gap_left--;
      req_valid <= 1'b0;
    end else if (chars_pending.size() == 0) begin
      req_valid <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      gap_left = $urandom_range(0, 8);
      req_valid <= 1'b0;
    end else begin
      next_char = chars_pending.pop_front();
      req_valid <= 1'b1;
      req_code  <= next_char.code;
      req_sot   <= next_char.sot;
      req_start <= next_char.start;
    end
  end

  // cell receiver, with one long hold-off to back up the request side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_ready <= 1'b0;
    end else begin
      if (cell_if.valid && cell_ready) cells_taken++;
      if (!long_hold_done && cells_taken >= 600) begin
        stall_left = 400;
        long_hold_done = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        cell_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 8);
        cell_ready <= 1'b0;
      end else begin
        cell_ready <= 1'b1;
      end
    end
  end

  // monitor: predict on accepted requests, check accepted cells
  always @(posedge clk_i) begin
    tbce_pkg::cell_t want;
    if (rst_ni) begin
      if (req_valid && req_if.ready) encode_char('{code: req_code, sot: req_sot,
                                                  start: req_start});
      if (cell_if.valid && cell_ready) begin
        if (cells_due.size() == 0) begin
          $display("%0t: unexpected cell idx %0d dots %02h last %0b", $time,
                   cell_if.cell_index, cell_if.dot_pattern, cell_if.last_of_char);
          mismatch_cnt++;
        end else begin
          want = cells_due.pop_front();
          if (cell_if.cell_index !== want.idx) begin
            $display("%0t: cell_index expected %0d actual %0d", $time, want.idx,
                     cell_if.cell_index);
            mismatch_cnt++;
          end
          if (cell_if.dot_pattern !== want.dots) begin
            $display("%0t: dot_pattern expected %02h actual %02h", $time, want.dots,
                     cell_if.dot_pattern);
            mismatch_cnt++;
          end
          if (cell_if.last_of_char !== want.last) begin
            $display("%0t: last_of_char expected %0b actual %0b", $time, want.last,
                     cell_if.last_of_char);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [1:0] reg_idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (reg_idx)
      tbce_pkg::RegNumSign: shadow_cfg.num_sign = value[PatW-1:0];
      tbce_pkg::RegCapSign: shadow_cfg.cap_sign = value[PatW-1:0];
      tbce_pkg::RegSpace:   shadow_cfg.space = value[PatW-1:0];
      tbce_pkg::RegMirror:  shadow_cfg.mirror = value[0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic add_char(input logic [7:0] code, input logic sot, input logic [7:0] start);
    chars_pending.push_back('{code: code, sot: sot, start: start});
  endtask

  function automatic logic [7:0] pick_char();
    int k;
    k = $urandom_range(0, 19);
    if (k < 6) return 8'($urandom_range(tbce_pkg::ChrLowerA, tbce_pkg::ChrLowerZ));
    if (k < 9) return 8'($urandom_range(tbce_pkg::ChrUpperA, tbce_pkg::ChrUpperZ));
    if (k < 14) return 8'($urandom_range(tbce_pkg::ChrDigit0, tbce_pkg::ChrDigit9));
    if (k < 16) return tbce_pkg::ChrSpace;
    if (k < 18) begin
      case ($urandom_range(0, 7))
        0: return tbce_pkg::ChrExcl;
        1: return tbce_pkg::ChrApos;
        2: return tbce_pkg::ChrHyphen;
        3: return tbce_pkg::ChrPeriod;
        4: return tbce_pkg::ChrComma;
        5: return tbce_pkg::ChrQuest;
        6: return tbce_pkg::ChrSemi;
        default: return tbce_pkg::ChrColon;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic queue_texts(input int n_chars);
    char_req_t r;
    int        run;
    while (n_chars > 0) begin
      run = $urandom_range(1, 20);
      for (int i = 0; i < run && n_chars > 0; i++) begin
        r.sot   = (i == 0) ? ($urandom_range(0, 15) != 0) : ($urandom_range(0, 40) == 0);
        r.start = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(16, 255))
                                                : 8'($urandom_range(0, 15));
        r.code  = pick_char();
        chars_pending.push_back(r);
        n_chars--;
      end
    end
  endtask

  task automatic wait_drained();
    int n;
    n = 0;
    while ((chars_pending.size() != 0 || req_valid || cells_due.size() != 0) && n < 20000) begin
      @(negedge clk_i);
      n++;
    end
    repeat (10) @(negedge clk_i);
    if (cells_due.size() != 0) begin
      $display("%0t: %0d cells never arrived", $time, cells_due.size());
      mismatch_cnt++;
    end
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    add_char(tbce_pkg::ChrLowerA, 1'b0, 8'd0);
    add_char(tbce_pkg::ChrUpperA, 1'b1, 8'd0);
    add_char(tbce_pkg::ChrLowerZ, 1'b0, 8'd0);
    add_char(tbce_pkg::ChrUpperZ, 1'b0, 8'd0);
    add_char(tbce_pkg::ChrDigit0, 1'b0, 8'd0);
    add_char(tbce_pkg::ChrDigit9, 1'b0, 8'd0);
    add_char(tbce_pkg::ChrSpace, 1'b0, 8'd0);
    add_char(tbce_pkg::ChrDigit0 + 8'd5, 1'b0, 8'd0);
    add_char(tbce_pkg::ChrExcl, 1'b1, 8'd0);
    add_char(tbce_pkg::ChrApos, 1'b0, 8'd0);
    add_char(tbce_pkg::ChrHyphen, 1'b0, 8'd0);
    add_char(tbce_pkg::ChrPeriod, 1'b0, 8'd0);
    add_char(tbce_pkg::ChrComma, 1'b0, 8'd0);
    add_char(tbce_pkg::ChrQuest, 1'b0, 8'd0);
    add_char(tbce_pkg::ChrSemi, 1'b0, 8'd0);
    add_char(tbce_pkg::ChrColon, 1'b0, 8'd0);
    add_char(8'h00, 1'b0, 8'd0);
    add_char(8'hFF, 1'b0, 8'd0);
    add_char(8'h80, 1'b0, 8'd0);
    add_char(tbce_pkg::ChrUpperA, 1'b1, 8'd255);
    add_char(tbce_pkg::ChrLowerA + 8'd1, 1'b0, 8'd0);
    add_char(tbce_pkg::ChrUpperA, 1'b1, 8'd15);
    add_char(tbce_pkg::ChrDigit0 + 8'd7, 1'b0, 8'd0);
    add_char(tbce_pkg::ChrDigit0 + 8'd3, 1'b1, 8'd14);
    add_char(tbce_pkg::ChrSpace, 1'b1, 8'd16);
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(tbce_pkg::RegNumSign, 32'd63);
          write_reg(tbce_pkg::RegCapSign, 32'd0);
          write_reg(tbce_pkg::RegSpace, 32'd63);
          write_reg(tbce_pkg::RegMirror, 32'd1);
        end
        1: begin
          write_reg(tbce_pkg::RegNumSign, 32'd0);
          write_reg(tbce_pkg::RegCapSign, 32'd63);
          write_reg(tbce_pkg::RegSpace, 32'd0);
          write_reg(tbce_pkg::RegMirror, 32'd0);
        end
        default: begin
          write_reg(tbce_pkg::RegNumSign, $urandom_range(0, 63));
          write_reg(tbce_pkg::RegCapSign, $urandom_range(0, 63));
          write_reg(tbce_pkg::RegSpace, $urandom_range(0, 63));
          write_reg(tbce_pkg::RegMirror, (ph == 4) ? 32'd1 : $urandom_range(0, 1));
        end
      endcase
      idle_on = (ph != 2 && ph != 4);
      queue_texts(285);
      wait_drained();
    end

    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
